/* rtl/core/dlr_pkg.sv */
`timescale 1ns / 1ps

package dlr_pkg;

    // Default coordinate width; the top level hands it down as COORD_BITS.
    localparam int DLR_COORD_BITS = 10;

    // Request codes carried on req_type.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Status codes driven on status.
    localparam logic STAT_POINT = 1'b0;
    localparam logic STAT_IDLE  = 1'b1;

    // Source of the point loaded into the output register.
    typedef enum logic [1:0] {
        SRC_ORIGIN,
        SRC_IDLE,
        SRC_CALC
    } out_src_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic     load_start;
        logic     load_step;
        logic     mul_en;
        logic     div_init;
        logic     div_step;
        logic     fix_en;
        logic     out_load;
        out_src_t out_src;
    } dlr_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic line_active;
        logic div_last;
    } dlr_stat_t;

endpackage

/* rtl/core/direct_line_rasterizer.sv */
// Direct line rasterizer, exact slope-intercept form with round half up.
// Start transaction: the origin goes via S_EMIT to the output register; a new transaction
// is taken only after that load. A step runs S_MUL, S_INIT, S_DIV (one-bit-per-cycle
// restoring divider), S_FIX, S_EMIT; a step with no active line emits the idle status.
// Reset (rst_n low, asynchronous) drops any active line and empties the output register.
`timescale 1ns / 1ps

module direct_line_rasterizer
#(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last_point,
    output logic                         status
);
    import dlr_pkg::*;

    // The controller sequences each transaction:
    //   start -> load endpoints, order them so the major axis increases, emit origin
    //   step  -> advance the index, multiply 2*d_minor*k, divide by 2*d_major
    //            one quotient bit a cycle, apply floor correction, emit point
    //   step with no line -> emit the idle status
    // The output register holds a finished point while the next transaction
    // is already being taken and worked on.
    dlr_cmd_t  cmd;
    dlr_stat_t stat;

    dlr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath keeps the line state (origin, deltas, major axis, step
    // index and total), the multiplier stage, the divider and the output register.
    dlr_dp
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .status     (status)
    );

endmodule

/* rtl/core/dlr_ctrl.sv */
`timescale 1ns / 1ps

module dlr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    output logic              out_valid,
    input  logic              out_ready,
    input  dlr_pkg::dlr_stat_t stat,
    output dlr_pkg::dlr_cmd_t  cmd
);
    import dlr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INIT,
        S_DIV,
        S_FIX,
        S_EMIT
    } state_t;

    state_t   state_reg, state_next;
    out_src_t src_reg, src_next;
    logic     out_valid_reg, out_valid_next;
    logic     accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.out_src    = src_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_START)
                    begin
                        cmd.load_start = 1'b1;
                        src_next       = SRC_ORIGIN;
                        state_next     = S_EMIT;
                    end
                    else if (stat.line_active)
                    begin
                        cmd.load_step = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        src_next   = SRC_IDLE;
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.fix_en = 1'b1;
                src_next   = SRC_CALC;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_reg       <= SRC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/dlr_dp.sv */
`timescale 1ns / 1ps

module dlr_dp
#(
    parameter int COORD_BITS = dlr_pkg::DLR_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dlr_pkg::dlr_cmd_t            cmd,
    output dlr_pkg::dlr_stat_t           stat,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last_point,
    output logic                         status
);
    import dlr_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int DW = N + 1;          // delta and step width
    localparam int PW = 2 * N + 3;      // product width
    localparam int NW = 2 * N + 4;      // numerator width
    localparam int QB = N + 1;          // quotient bits
    localparam int RW = N + 2;          // remainder and divisor width
    localparam int CW = $clog2(QB);

    // line state
    logic             active_reg;
    logic [N-1:0]     org_x_reg, org_y_reg;
    logic [DW-1:0]    dlt_x_reg, dlt_y_reg;
    logic             major_x_reg;
    logic [DW-1:0]    step_idx_reg, step_tot_reg;
    logic             last_reg;

    // arithmetic
    logic [PW-1:0]    prod_reg;
    logic             neg_reg;
    logic [RW-1:0]    rem_reg;
    logic [QB-1:0]    qsh_reg;
    logic [CW-1:0]    cnt_reg;
    logic [N-1:0]     minor_reg;

    // output register
    logic [N-1:0]     px_reg, py_reg;
    logic             last_out_reg, stat_reg;

    // start decode
    logic signed [DW-1:0] dx_s, dy_s, dxn_s, dyn_s;
    logic [DW-1:0]        adx, ady, stot_s;
    logic                 major_s, swap_s;
    logic [DW-1:0]        step_inc;

    always_comb
    begin
        dx_s    = $signed({end_x[N-1], end_x}) - $signed({start_x[N-1], start_x});
        dy_s    = $signed({end_y[N-1], end_y}) - $signed({start_y[N-1], start_y});
        adx     = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
        ady     = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
        major_s = ady < adx;
        swap_s  = major_s ? dx_s[DW-1] : dy_s[DW-1];
        dxn_s   = swap_s ? -dx_s : dx_s;
        dyn_s   = swap_s ? -dy_s : dy_s;
        stot_s  = major_s ? DW'(dxn_s) : DW'(dyn_s);
    end

    assign step_inc = step_idx_reg + DW'(1);

    // minor and major axis selection
    logic signed [DW-1:0] dmin;
    logic [DW-1:0]        dmaj;
    logic [N-1:0]         org_min, org_maj;
    logic signed [PW-1:0] prod_s;

    assign dmin    = major_x_reg ? $signed(dlt_y_reg) : $signed(dlt_x_reg);
    assign dmaj    = major_x_reg ? dlt_x_reg : dlt_y_reg;
    assign org_min = major_x_reg ? org_y_reg : org_x_reg;
    assign org_maj = major_x_reg ? org_x_reg : org_y_reg;
    assign prod_s  = dmin * $signed({1'b0, step_idx_reg});

    // numerator 2*dmin*k + dmaj, split into sign and magnitude
    logic [NW-1:0] num, num_mag;
    assign num     = ({{(NW-PW){prod_reg[PW-1]}}, prod_reg} << 1)
                   + {{(NW-DW){1'b0}}, dmaj};
    assign num_mag = num[NW-1] ? (~num + NW'(1)) : num;

    // restoring division step by divisor 2*dmaj
    logic [RW-1:0] dvs, trial;
    logic          qbit;
    assign dvs   = {dmaj, 1'b0};
    assign trial = {rem_reg[RW-2:0], qsh_reg[QB-1]};
    assign qbit  = trial >= dvs;

    // floor correction for negative numerators
    logic [RW-1:0] qmag, qsig, minor_sum;
    assign qmag      = {1'b0, qsh_reg} + RW'((neg_reg && (rem_reg != '0)) ? 1 : 0);
    assign qsig      = neg_reg ? (~qmag + RW'(1)) : qmag;
    assign minor_sum = {{(RW-N){org_min[N-1]}}, org_min} + qsig;

    logic [N-1:0] major_pt;
    assign major_pt = org_maj + step_idx_reg[N-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            dlt_x_reg    <= '0;
            dlt_y_reg    <= '0;
            major_x_reg  <= 1'b0;
            step_idx_reg <= '0;
            step_tot_reg <= '0;
            last_reg     <= 1'b0;
        end
        else if (cmd.load_start)
        begin
            active_reg   <= (stot_s != '0);
            org_x_reg    <= swap_s ? end_x : start_x;
            org_y_reg    <= swap_s ? end_y : start_y;
            dlt_x_reg    <= DW'(dxn_s);
            dlt_y_reg    <= DW'(dyn_s);
            major_x_reg  <= major_s;
            step_idx_reg <= '0;
            step_tot_reg <= stot_s;
            last_reg     <= (stot_s == '0);
        end
        else if (cmd.load_step)
        begin
            step_idx_reg <= step_inc;
            last_reg     <= (step_inc >= step_tot_reg);
            // drop the line once its final point is on its way
            active_reg   <= !(step_inc >= step_tot_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= PW'(prod_s);
        end
        if (cmd.div_init)
        begin
            neg_reg <= num[NW-1];
            rem_reg <= num_mag[QB+RW-1:QB];
            qsh_reg <= num_mag[QB-1:0];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? (trial - dvs) : trial;
            qsh_reg <= {qsh_reg[QB-2:0], qbit};
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.fix_en)
        begin
            minor_reg <= minor_sum[N-1:0];
        end
        if (cmd.out_load)
        begin
            case (cmd.out_src)
                SRC_ORIGIN:
                begin
                    px_reg       <= org_x_reg;
                    py_reg       <= org_y_reg;
                    last_out_reg <= last_reg;
                    stat_reg     <= STAT_POINT;
                end
                SRC_CALC:
                begin
                    px_reg       <= major_x_reg ? major_pt : minor_reg;
                    py_reg       <= major_x_reg ? minor_reg : major_pt;
                    last_out_reg <= last_reg;
                    stat_reg     <= STAT_POINT;
                end
                default:
                begin
                    px_reg       <= '0;
                    py_reg       <= '0;
                    last_out_reg <= 1'b0;
                    stat_reg     <= STAT_IDLE;
                end
            endcase
        end
    end

    assign stat.line_active = active_reg;
    assign stat.div_last    = (cnt_reg == CW'(QB - 1));

    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = last_out_reg;
    assign status     = stat_reg;

endmodule
